@@ rtl/mi3_pkg.sv @@
// Shared constants, tables and types for the 3x3 matrix inverse core.
`default_nettype none
package mi3_pkg;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int THR_WIDTH      = 16;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;
   localparam int N_ELEM         = 9;

   // Each output position takes the cofactor of the transposed position,
   // formed as a*b - c*d over the row-major element indexes.
   localparam int COF_TAB [N_ELEM][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic valid;
      logic singular;
      logic det_sat;
   } mi3_side_type;
endpackage
`default_nettype wire

@@ rtl/mi3_front.sv @@
// Cofactor, determinant and divider setup pipeline.
`default_nettype none
module mi3_front
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int E  = ELEM_WIDTH,
   localparam int AW = 2 * E + 1,
   localparam int DP = 3 * E + 1,
   localparam int DW = 3 * E + 3,
   localparam int NW = AW + 2 * FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [E-1:0]   m_in [N_ELEM],
   input  logic [THR_WIDTH-1:0]  threshold,
   output mi3_side_type          side_out,
   output logic signed [E-1:0]   m_out [N_ELEM],
   output logic [NW-1:0]         num_out [N_ELEM],
   output logic                  neg_out [N_ELEM],
   output logic [DW-1:0]         den_out,
   output logic signed [E-1:0]   det_out
);
   localparam int F2 = 2 * FRAC_BITS;
   localparam int CW = (DW > THR_WIDTH + F2) ? DW : THR_WIDTH + F2;

   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic signed [E-1:0]    ma_ff [N_ELEM];
   logic signed [E-1:0]    mb_ff [N_ELEM];
   logic signed [E-1:0]    mc_ff [N_ELEM];
   logic signed [E-1:0]    md_ff [N_ELEM];
   logic signed [E-1:0]    me_ff [N_ELEM];
   logic signed [E-1:0]    mf_ff [N_ELEM];
   logic signed [2*E-1:0]  p_ff [N_ELEM];
   logic signed [2*E-1:0]  q_ff [N_ELEM];
   logic signed [AW-1:0]   adjc_ff [N_ELEM];
   logic signed [AW-1:0]   adjd_ff [N_ELEM];
   logic signed [AW-1:0]   adje_ff [N_ELEM];
   logic signed [AW-1:0]   adjf_ff [N_ELEM];
   logic signed [2*E:0]    lo_ff [3];
   logic signed [2*E:0]    hi_ff [3];
   logic signed [DP-1:0]   prod_ff [3];
   logic signed [DW-1:0]   det_ff;

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         side_out.valid <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         side_out.valid <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_ELEM; i++) begin
         ma_ff[i]   <= m_in[i];
         mb_ff[i]   <= ma_ff[i];
         p_ff[i]    <= (2*E)'(ma_ff[COF_TAB[i][0]]) * (2*E)'(ma_ff[COF_TAB[i][1]]);
         q_ff[i]    <= (2*E)'(ma_ff[COF_TAB[i][2]]) * (2*E)'(ma_ff[COF_TAB[i][3]]);
         mc_ff[i]   <= mb_ff[i];
         adjc_ff[i] <= AW'(p_ff[i]) - AW'(q_ff[i]);
         md_ff[i]   <= mc_ff[i];
         adjd_ff[i] <= adjc_ff[i];
         me_ff[i]   <= md_ff[i];
         adje_ff[i] <= adjd_ff[i];
         mf_ff[i]   <= me_ff[i];
         adjf_ff[i] <= adje_ff[i];
      end
      // The determinant expands along row 0; each AW-bit-wide cofactor is
      // split so that no multiplier exceeds the element width by more than a bit.
      for (int j = 0; j < 3; j++) begin
         lo_ff[j]   <= AW'(mc_ff[j]) * AW'($signed({1'b0, adjc_ff[3*j][E-1:0]}));
         hi_ff[j]   <= AW'(mc_ff[j]) * AW'($signed(adjc_ff[3*j][AW-1:E]));
         prod_ff[j] <= $signed({hi_ff[j], {E{1'b0}}}) + DP'(lo_ff[j]);
      end
      det_ff <= DW'(prod_ff[0]) + DW'(prod_ff[1]) + DW'(prod_ff[2]);
   end

   // Setup stage: magnitudes, signs, threshold test and the scaled determinant.
   logic                  det_neg;
   logic [DW-1:0]         det_mag;
   logic [CW-1:0]         thr_scaled;
   logic signed [DW-1:0]  det_rnd;
   logic signed [DW-1:0]  det_shift;
   logic                  det_fits;
   logic [AW-1:0]         adj_mag [N_ELEM];

   always_comb begin
      det_neg    = det_ff[DW-1];
      det_mag    = det_neg ? DW'(-det_ff) : DW'(det_ff);
      thr_scaled = CW'(threshold) << F2;
      det_rnd    = det_neg ? det_ff + DW'((DW'(1) << F2) - DW'(1)) : det_ff;
      det_shift  = det_rnd >>> F2;
      det_fits   = (det_shift[DW-1:E-1] == '0) || (det_shift[DW-1:E-1] == '1);
      for (int i = 0; i < N_ELEM; i++) begin
         adj_mag[i] = adjf_ff[i][AW-1] ? AW'(-adjf_ff[i]) : AW'(adjf_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_ELEM; i++) begin
         m_out[i]   <= mf_ff[i];
         num_out[i] <= {adj_mag[i], {F2{1'b0}}};
         neg_out[i] <= adjf_ff[i][AW-1] ^ det_neg;
      end
      den_out           <= det_mag;
      side_out.singular <= (det_ff == '0) || (CW'(det_mag) < thr_scaled);
      side_out.det_sat  <= !det_fits;
      if (det_fits) begin
         det_out <= det_shift[E-1:0];
      end else if (det_shift[DW-1]) begin
         det_out <= {1'b1, {(E-1){1'b0}}};
      end else begin
         det_out <= {1'b0, {(E-1){1'b1}}};
      end
   end
endmodule
`default_nettype wire

@@ rtl/mi3_div_lane.sv @@
// One divider lane: pipelined restoring division with saturation to the element range.
`default_nettype none
module mi3_div_lane
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int E  = ELEM_WIDTH,
   localparam int DW = 3 * E + 3,
   localparam int NW = 2 * E + 1 + 2 * FRAC_BITS
) (
   input  logic                 clock,
   input  logic [NW-1:0]        num,
   input  logic [DW-1:0]        den,
   input  logic                 neg,
   output logic signed [E-1:0]  quo,
   output logic                 sat
);
   localparam int QB = E + 1;
   localparam int RH = NW - QB;
   localparam int XW = ((RH > DW) ? RH : DW) + 1;

   logic [DW-1:0] rem_ff [QB+1];
   logic [QB-1:0] low_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [DW-1:0] den_ff [QB+1];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];

   // A quotient of 2^QB or more saturates whatever its sign.
   always_ff @(posedge clock) begin
      rem_ff[0] <= DW'(num[NW-1:QB]);
      low_ff[0] <= num[QB-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= den;
      neg_ff[0] <= neg;
      ovf_ff[0] <= XW'(num[NW-1:QB]) >= XW'(den);
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DW:0] shifted;
      logic        fits;
      assign shifted = {rem_ff[k], low_ff[k][QB-1-k]};
      assign fits    = shifted >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? DW'(shifted - {1'b0, den_ff[k]}) : shifted[DW-1:0];
         low_ff[k+1] <= low_ff[k];
         q_ff[k+1]   <= {q_ff[k][QB-2:0], fits};
         den_ff[k+1] <= den_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   logic [QB-1:0] qmag;
   logic [QB-1:0] qneg;
   always_comb begin
      qmag = q_ff[QB];
      qneg = QB'(~qmag + QB'(1));
      if (neg_ff[QB]) begin
         sat = ovf_ff[QB] || (qmag > {2'b01, {(E-1){1'b0}}});
         quo = sat ? {1'b1, {(E-1){1'b0}}} : qneg[E-1:0];
      end else begin
         sat = ovf_ff[QB] || (qmag > {2'b00, {(E-1){1'b1}}});
         quo = sat ? {1'b0, {(E-1){1'b1}}} : qmag[E-1:0];
      end
   end
endmodule
`default_nettype wire

@@ rtl/mi3_merge.sv @@
// Merging stage: picks inverse or pass-through and registers the response.
`default_nettype none
module mi3_merge
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   localparam int E = ELEM_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mi3_side_type         side,
   input  logic signed [E-1:0]  m_in [N_ELEM],
   input  logic signed [E-1:0]  quo [N_ELEM],
   input  logic                 qsat [N_ELEM],
   input  logic signed [E-1:0]  det_in,
   output logic                 valid_ff,
   output logic signed [E-1:0]  r_ff [N_ELEM],
   output logic signed [E-1:0]  det_ff,
   output logic                 sing_ff,
   output logic                 sat_ff
);
   logic any_sat;
   always_comb begin
      any_sat = 1'b0;
      for (int i = 0; i < N_ELEM; i++) begin
         any_sat = any_sat | qsat[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side.valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_ELEM; i++) begin
         r_ff[i] <= side.singular ? m_in[i] : quo[i];
      end
      det_ff  <= det_in;
      sing_ff <= side.singular;
      sat_ff  <= side.det_sat | (!side.singular & any_sat);
   end
endmodule
`default_nettype wire

@@ rtl/matrix3_inverse_core.sv @@
// Top level of the 3x3 matrix inverse core (adjugate over determinant).
//
//   Channel    Ports                              Handshake
//   request    start, busy, req_m00..req_m22      taken when start is high, busy low
//   response   rsp_valid, rsp_r00..rsp_saturated  one-cycle strobe, no back-pressure
//   register   csr_write_enable, csr_write_data   written on any enabled edge
//
// The core is fully pipelined and accepts one request every clock cycle;
// busy is always low. A response passes through the cofactor and
// determinant arithmetic, the nine divider lanes, which retire one
// quotient bit per stage, and one merging register. Reset is synchronous
// and clears only the valid pipeline and the threshold register, which
// returns to 1. The receiver cannot stall, so every response is
// presented for exactly one cycle.
`default_nettype none
module matrix3_inverse_core
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ELEM_WIDTH-1:0]  req_m00,
   input  logic signed [ELEM_WIDTH-1:0]  req_m01,
   input  logic signed [ELEM_WIDTH-1:0]  req_m02,
   input  logic signed [ELEM_WIDTH-1:0]  req_m10,
   input  logic signed [ELEM_WIDTH-1:0]  req_m11,
   input  logic signed [ELEM_WIDTH-1:0]  req_m12,
   input  logic signed [ELEM_WIDTH-1:0]  req_m20,
   input  logic signed [ELEM_WIDTH-1:0]  req_m21,
   input  logic signed [ELEM_WIDTH-1:0]  req_m22,
   output logic                          rsp_valid,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r00,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r01,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r02,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r10,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r11,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r12,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r20,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r21,
   output logic signed [ELEM_WIDTH-1:0]  rsp_r22,
   output logic signed [ELEM_WIDTH-1:0]  rsp_determinant,
   output logic                          rsp_singular,
   output logic                          rsp_saturated,
   input  logic                          csr_write_enable,
   input  logic [THR_WIDTH-1:0]          csr_write_data
);
   localparam int E   = ELEM_WIDTH;
   localparam int DW  = 3 * E + 3;
   localparam int NW  = 2 * E + 1 + 2 * FRAC_BITS;
   // Side data waits in a delay line as long as the divider lanes take.
   localparam int LAT = E + 2;

   // The user must rewrite the threshold only while no request is in flight; the block does not enforce it.
   logic [THR_WIDTH-1:0] threshold_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   logic signed [E-1:0] m_req [N_ELEM];
   assign m_req = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                    req_m20, req_m21, req_m22};

   mi3_side_type         front_side;
   logic signed [E-1:0]  front_m [N_ELEM];
   logic [NW-1:0]        front_num [N_ELEM];
   logic                 front_neg [N_ELEM];
   logic [DW-1:0]        front_den;
   logic signed [E-1:0]  front_det;

   mi3_front #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & !busy),
      .m_in      (m_req),
      .threshold (threshold_ff),
      .side_out  (front_side),
      .m_out     (front_m),
      .num_out   (front_num),
      .neg_out   (front_neg),
      .den_out   (front_den),
      .det_out   (front_det)
   );

   // Nine identical lanes, one per adjugate element, all sharing the
   // determinant as divisor.
   logic signed [E-1:0] lane_quo [N_ELEM];
   logic                lane_sat [N_ELEM];
   for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
      mi3_div_lane #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .num   (front_num[i]),
         .den   (front_den),
         .neg   (front_neg[i]),
         .quo   (lane_quo[i]),
         .sat   (lane_sat[i])
      );
   end

   // Delay line for the pass-through matrix, determinant and flags. Only
   // the valid bits are reset; the data simply shifts along.
   mi3_side_type         side_ff [LAT];
   logic signed [E-1:0]  mat_ff  [LAT][N_ELEM];
   logic signed [E-1:0]  det_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else begin
         side_ff[0].valid <= front_side.valid;
         for (int k = 1; k < LAT; k++) begin
            side_ff[k].valid <= side_ff[k-1].valid;
         end
      end
      side_ff[0].singular <= front_side.singular;
      side_ff[0].det_sat  <= front_side.det_sat;
      mat_ff[0]           <= front_m;
      det_ff[0]           <= front_det;
      for (int k = 1; k < LAT; k++) begin
         side_ff[k].singular <= side_ff[k-1].singular;
         side_ff[k].det_sat  <= side_ff[k-1].det_sat;
         mat_ff[k]           <= mat_ff[k-1];
         det_ff[k]           <= det_ff[k-1];
      end
   end

   logic signed [E-1:0] rsp_r [N_ELEM];

   mi3_merge #(.ELEM_WIDTH(ELEM_WIDTH)) u_merge (
      .clock    (clock),
      .reset    (reset),
      .side     (side_ff[LAT-1]),
      .m_in     (mat_ff[LAT-1]),
      .quo      (lane_quo),
      .qsat     (lane_sat),
      .det_in   (det_ff[LAT-1]),
      .valid_ff (rsp_valid),
      .r_ff     (rsp_r),
      .det_ff   (rsp_determinant),
      .sing_ff  (rsp_singular),
      .sat_ff   (rsp_saturated)
   );

   assign rsp_r00 = rsp_r[0];
   assign rsp_r01 = rsp_r[1];
   assign rsp_r02 = rsp_r[2];
   assign rsp_r10 = rsp_r[3];
   assign rsp_r11 = rsp_r[4];
   assign rsp_r12 = rsp_r[5];
   assign rsp_r20 = rsp_r[6];
   assign rsp_r21 = rsp_r[7];
   assign rsp_r22 = rsp_r[8];
endmodule
`default_nettype wire

@@ tb/tb_matrix3_inverse_core.sv @@
// Self-checking testbench for the 3x3 matrix inverse core.
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix3_inverse_core;
   import mi3_pkg::*;

   localparam int EW = ELEM_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   // Response latency of the core.
   localparam int LATENCY = EW + 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [EW-1:0] elem_type;
   // Full-width signed arithmetic. Products of three 32-bit elements need
   // about 100 bits, and the shifted adjugate needs about 97.
   typedef logic signed [159:0] wide_type;

   typedef struct {
      elem_type r [9];
      elem_type det;
      logic     singular;
      logic     saturated;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   elem_type req_m [9];
   logic rsp_valid;
   elem_type rsp_r [9];
   elem_type rsp_determinant;
   logic rsp_singular, rsp_saturated;
   logic csr_write_enable = 1'b0;
   logic [THR_WIDTH-1:0] csr_write_data = '0;

   // Threshold as the predictor sees it; mirrors the register.
   logic [THR_WIDTH-1:0] threshold_shadow = THR_RESET;
   inverse_type expected_inverses[$];
   int errors = 0;
   int idle_cycles = 0;
   bit allow_gaps = 1'b1;

   initial begin
      for (int i = 0; i < 9; i++) req_m[i] = '0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   matrix3_inverse_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid),
      .rsp_r00(rsp_r[0]), .rsp_r01(rsp_r[1]), .rsp_r02(rsp_r[2]),
      .rsp_r10(rsp_r[3]), .rsp_r11(rsp_r[4]), .rsp_r12(rsp_r[5]),
      .rsp_r20(rsp_r[6]), .rsp_r21(rsp_r[7]), .rsp_r22(rsp_r[8]),
      .rsp_determinant(rsp_determinant),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // Clamp a wide value into the element range, noting any clamp.
   function automatic elem_type clamp_elem(input wide_type v, inout logic hit);
      wide_type hi, lo;
      hi = wide_type'({1'b0, {(EW-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1'b1;
         return {1'b0, {(EW-1){1'b1}}};
      end
      if (v < lo) begin
         hit = 1'b1;
         return {1'b1, {(EW-1){1'b0}}};
      end
      return v[EW-1:0];
   endfunction

   // Adjugate over determinant. The SystemVerilog signed division truncates
   // toward zero, which is the rounding the core uses.
   function automatic inverse_type invert_matrix(input elem_type m [9]);
      inverse_type res;
      wide_type w [9];
      wide_type adj [9];
      wide_type det, mag, thr;
      int tab [9][4];
      logic sat;
      tab = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
              '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
              '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
      sat = 1'b0;
      for (int i = 0; i < 9; i++) w[i] = m[i];
      for (int i = 0; i < 9; i++)
         adj[i] = w[tab[i][0]] * w[tab[i][1]] - w[tab[i][2]] * w[tab[i][3]];
      // Output positions 0, 3 and 6 hold the cofactors of row 0.
      det = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
      res.det = clamp_elem(det / (wide_type'(1) <<< (2 * FB)), sat);
      mag = (det < 0) ? -det : det;
      thr = wide_type'(threshold_shadow) <<< (2 * FB);
      // A zero determinant is singular even with a zero threshold.
      res.singular = (det == 0) || (mag < thr);
      for (int i = 0; i < 9; i++) begin
         if (res.singular) res.r[i] = m[i];
         else res.r[i] = clamp_elem((adj[i] <<< (2 * FB)) / det, sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   // Response checker: every strobe is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            $display("%0t: unexpected response, det %h", $time, rsp_determinant);
            errors++;
         end else begin
            inverse_type e;
            e = expected_inverses.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_r[i] !== e.r[i]) begin
                  $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                           e.r[i], rsp_r[i]);
                  errors++;
               end
            if (rsp_determinant !== e.det) begin
               $display("%0t: determinant expected %h actual %h", $time, e.det,
                        rsp_determinant);
               errors++;
            end
            if (rsp_singular !== e.singular) begin
               $display("%0t: singular expected %b actual %b", $time, e.singular,
                        rsp_singular);
               errors++;
            end
            if (rsp_saturated !== e.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles with no request or response accepted.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_matrix3_inverse_core: FAIL");
         $finish;
      end
   end

   // Send one request, with an optional random gap before it. The prediction
   // is queued at the accepting edge, so the strobe always finds it.
   task automatic send_matrix(input elem_type m [9]);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) req_m[i] <= m[i];
      do @(posedge clock); while (busy);
      expected_inverses.push_back(invert_matrix(m));
   endtask

   // Lower start and wait until every response is in, then let the pipe drain.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (expected_inverses.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Threshold writes happen only with the pipeline empty.
   task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_shadow = value;
   endtask

   function automatic elem_type random_elem(input int mode);
      case (mode)
         0: return $urandom();
         // Values near one keep the determinant well away from overflow.
         1: return $signed($urandom_range(0, 4 << FB)) - (2 << FB);
         2: return $signed($urandom_range(0, 512)) - 256;
         default: return $urandom_range(0, 1) ? {1'b0, {(EW-1){1'b1}}}
                                              : {1'b1, {(EW-1){1'b0}}};
      endcase
   endfunction

   task automatic test_directed();
      elem_type m [9];
      elem_type one, maxv, minv;
      one = elem_type'(1) <<< FB;
      maxv = {1'b0, {(EW-1){1'b1}}};
      minv = {1'b1, {(EW-1){1'b0}}};
      // Identity and a scaled diagonal invert cleanly.
      m = '{one, 0, 0, 0, one, 0, 0, 0, one};
      send_matrix(m);
      m = '{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2};
      send_matrix(m);
      // Zero matrix and a rank-deficient one pass through as singular.
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(m);
      m = '{one, 2 * one, 3 * one, 2 * one, 4 * one, 6 * one, one, 0, one};
      send_matrix(m);
      // Extreme elements clamp the determinant and the inverse.
      m = '{maxv, 0, 0, 0, maxv, 0, 0, 0, maxv};
      send_matrix(m);
      m = '{minv, 0, 0, 0, minv, 0, 0, 0, minv};
      send_matrix(m);
      m = '{minv, maxv, minv, maxv, minv, maxv, minv, maxv, maxv};
      send_matrix(m);
      // Tiny elements fall under the threshold and pass through as singular.
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(m);
      m = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
      send_matrix(m);
      m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_matrix(m);
      m = '{0, one, 0, 0, 0, one, one, 0, 0};
      send_matrix(m);
      drain_pipeline();
   endtask

   task automatic test_threshold_settings();
      elem_type m [9];
      logic [THR_WIDTH-1:0] settings [4];
      settings = '{16'd0, 16'hFFFF, 16'h8000, 16'd3};
      foreach (settings[s]) begin
         write_threshold(settings[s]);
         for (int k = 0; k < 12; k++) begin
            // Diagonal matrices put the determinant near the threshold.
            m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
            m[0] = random_elem(1);
            m[4] = random_elem(1);
            m[8] = (k % 3 == 0) ? random_elem(2) : random_elem(1);
            if (k == 0) m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
            send_matrix(m);
         end
         drain_pipeline();
      end
   endtask

   task automatic test_random(input int count);
      elem_type m [9];
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++)
            m[i] = (mode < 5) ? random_elem(1) : (mode < 8) ? random_elem(0)
                 : random_elem($urandom_range(0, 3));
         // Some rows are copied to make singular inputs.
         if (mode == 4) for (int i = 0; i < 3; i++) m[6 + i] = m[i];
         send_matrix(m);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold_settings();
      write_threshold(16'd1);
      // Random traffic with gaps, then a full drain before the next phase.
      test_random(300);
      drain_pipeline();
      write_threshold(16'd20);
      allow_gaps = 1'b0;
      test_random(100);
      drain_pipeline();
      if (errors == 0) $display("tb_matrix3_inverse_core: PASS");
      else $display("tb_matrix3_inverse_core: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

@@ matrix3_inverse_core.f @@
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/mi3_merge.sv
rtl/matrix3_inverse_core.sv
tb/tb_matrix3_inverse_core.sv
